// File: design/ksrb_pkg.sv
// Shared constants, result codes and the scan code table for the keyboard scan code ring.
package ksrb_pkg;

    localparam int BUFFER_DEPTH = 32;
    localparam int PTR_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);

    localparam logic [7:0] SC_RIGHT   = 8'h4d;
    localparam logic [7:0] SC_LEFT    = 8'h4b;
    localparam logic [7:0] SC_ALT     = 8'h38;
    localparam logic [7:0] SC_SHIFT   = 8'h2a;
    localparam logic [7:0] SC_RELEASE = 8'h80;

    localparam logic CMD_SCAN = 1'b0;
    localparam logic CMD_READ = 1'b1;

    typedef enum logic [2:0] {
        KIND_DATA      = 3'd0,
        KIND_TOO_LARGE = 3'd1,
        KIND_BUSY      = 3'd2,
        KIND_SW_RIGHT  = 3'd3,
        KIND_SW_LEFT   = 3'd4
    } kind_t;

    // Character for a set 1 make code; zero means the code stores nothing.
    function automatic logic [7:0] map_code(input logic [7:0] sc);
        logic [7:0] ch;
        ch = 8'h00;
        case (sc) inside
            8'h1e: ch = "a";
            8'h30: ch = "b";
            8'h2e: ch = "c";
            8'h20: ch = "d";
            8'h12: ch = "e";
            8'h21: ch = "f";
            8'h22: ch = "g";
            8'h23: ch = "h";
            8'h17: ch = "i";
            8'h24: ch = "j";
            8'h25: ch = "k";
            8'h26: ch = "l";
            8'h32: ch = "m";
            8'h31: ch = "n";
            8'h18: ch = "o";
            8'h19: ch = "p";
            8'h10: ch = "q";
            8'h13: ch = "r";
            8'h1f: ch = "s";
            8'h14: ch = "t";
            8'h16: ch = "u";
            8'h2f: ch = "v";
            8'h11: ch = "w";
            8'h2d: ch = "x";
            8'h15: ch = "y";
            8'h2c: ch = "z";
            8'h02: ch = "1";
            8'h03: ch = "2";
            8'h04: ch = "3";
            8'h05: ch = "4";
            8'h06: ch = "5";
            8'h07: ch = "6";
            8'h08: ch = "7";
            8'h09: ch = "8";
            8'h0a: ch = "9";
            8'h0b: ch = "0";
            8'h34: ch = ".";
            8'h39: ch = " ";
            8'h1c: ch = 8'h0a;
            8'h0f: ch = 8'h09;
            8'h0e: ch = 8'h08;
            [8'h3b:8'h44], [8'h57:8'h58]: ch = "_";
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (32'(p) == BUFFER_DEPTH - 1) ? '0 : p + PTR_W'(1);
    endfunction

endpackage

// File: design/ksrb_ifs.sv
// Valid/ready channel interfaces for the request and result sides.
interface ksrb_req_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [7:0] key_code;
    logic [5:0] read_size;

    modport source (output valid, cmd, key_code, read_size, input ready);
    modport sink (input valid, cmd, key_code, read_size, output ready);
endinterface

interface ksrb_rsp_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic [7:0] data_byte;
    logic       last;

    modport source (output valid, kind, data_byte, last, input ready);
    modport sink (input valid, kind, data_byte, last, output ready);
endinterface

// File: design/keyboard_scancode_ring_buffer.sv
// Keyboard scan code ring: maps set 1 codes to characters and serves blocking reads.
//
//  channel  dir  payload                      transfer when
//  req      in   cmd, key_code, read_size     req.valid && req.ready
//  rsp      out  kind, data_byte, last        rsp.valid && rsp.ready
//
// A request with no result leaves the block idle. A switch or error result passes through
// ST_SINGLE into the output register once the slot is free, and the block stays busy until then.
// A read of N bytes passes through ST_DELIVER, which loads one byte per cycle into the output
// register while the slot is free, paced by the single read port of the ring and the shared
// byte counter; rsp stalls hold it back. The block takes a new request only once the previous
// one has loaded all its results, but a read left waiting for bytes does not block it.
// Reset clears pointers, counts and flags at once; the ring itself is not cleared.
module keyboard_scancode_ring_buffer (
    input logic     clk,
    input logic     rst_n,
    ksrb_req_if.sink   req,
    ksrb_rsp_if.source rsp
);
    import ksrb_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SINGLE,
        ST_DELIVER
    } state_t;

    logic [7:0] ring [BUFFER_DEPTH];

    state_t           state_reg, state_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] remain_reg, remain_next;
    logic             pending_reg, pending_next;
    logic [CNT_W-1:0] pend_size_reg, pend_size_next;
    logic             alt_reg, alt_next;
    logic             shift_reg, shift_next;
    kind_t            single_kind_reg, single_kind_next;
    logic             out_valid_reg, out_valid_next;
    kind_t            out_kind_reg, out_kind_next;
    logic             out_last_reg, out_last_next;
    logic [7:0]       data_byte_reg;

    logic             accept;
    logic             slot_free;
    logic             load_byte;
    logic             ring_we;
    logic [7:0]       ch;

    assign accept    = req.valid && req.ready;
    assign slot_free = !out_valid_reg || rsp.ready;
    assign load_byte = (state_reg == ST_DELIVER) && slot_free;
    assign ch        = map_code(req.key_code);
    assign ring_we   = accept && (req.cmd == CMD_SCAN) && (ch != 8'h00)
                       && (32'(count_reg) < BUFFER_DEPTH);

    assign req.ready     = (state_reg == ST_IDLE);
    assign rsp.valid     = out_valid_reg;
    assign rsp.kind      = out_kind_reg;
    assign rsp.data_byte = data_byte_reg;
    assign rsp.last      = out_last_reg;

    always_comb
    begin
        state_next       = state_reg;
        rd_ptr_next      = rd_ptr_reg;
        wr_ptr_next      = wr_ptr_reg;
        count_next       = count_reg;
        remain_next      = remain_reg;
        pending_next     = pending_reg;
        pend_size_next   = pend_size_reg;
        alt_next         = alt_reg;
        shift_next       = shift_reg;
        single_kind_next = single_kind_reg;
        out_valid_next   = out_valid_reg && !rsp.ready;
        out_kind_next    = out_kind_reg;
        out_last_next    = out_last_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (req.cmd == CMD_SCAN)
                    begin
                        // The switch check sees the flags as they stood before this code.
                        if (alt_reg && shift_reg && req.key_code == SC_RIGHT)
                        begin
                            single_kind_next = KIND_SW_RIGHT;
                            state_next       = ST_SINGLE;
                        end
                        else if (alt_reg && shift_reg && req.key_code == SC_LEFT)
                        begin
                            single_kind_next = KIND_SW_LEFT;
                            state_next       = ST_SINGLE;
                        end
                        if (req.key_code == SC_ALT)
                            alt_next = 1'b1;
                        else if (req.key_code == (SC_ALT | SC_RELEASE))
                            alt_next = 1'b0;
                        if (req.key_code == SC_SHIFT)
                            shift_next = 1'b1;
                        else if (req.key_code == (SC_SHIFT | SC_RELEASE))
                            shift_next = 1'b0;
                        if (ring_we)
                        begin
                            wr_ptr_next = bump(wr_ptr_reg);
                            count_next  = count_reg + CNT_W'(1);
                            if (pending_reg && count_reg + CNT_W'(1) >= pend_size_reg)
                            begin
                                pending_next   = 1'b0;
                                pend_size_next = '0;
                                remain_next    = pend_size_reg;
                                state_next     = ST_DELIVER;
                            end
                        end
                    end
                    else if (32'(req.read_size) > BUFFER_DEPTH)
                    begin
                        single_kind_next = KIND_TOO_LARGE;
                        state_next       = ST_SINGLE;
                    end
                    else if (pending_reg)
                    begin
                        single_kind_next = KIND_BUSY;
                        state_next       = ST_SINGLE;
                    end
                    else if (32'(count_reg) >= 32'(req.read_size))
                    begin
                        // A read of zero bytes completes with no result.
                        if (req.read_size != 6'd0)
                        begin
                            remain_next = CNT_W'(req.read_size);
                            state_next  = ST_DELIVER;
                        end
                    end
                    else
                    begin
                        pending_next   = 1'b1;
                        pend_size_next = CNT_W'(req.read_size);
                    end
                end
            end
            ST_SINGLE:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = single_kind_reg;
                    out_last_next  = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_DELIVER:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_DATA;
                    out_last_next  = (remain_reg == CNT_W'(1));
                    rd_ptr_next    = bump(rd_ptr_reg);
                    count_next     = count_reg - CNT_W'(1);
                    remain_next    = remain_reg - CNT_W'(1);
                    if (remain_reg == CNT_W'(1))
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            rd_ptr_reg      <= '0;
            wr_ptr_reg      <= '0;
            count_reg       <= '0;
            remain_reg      <= '0;
            pending_reg     <= 1'b0;
            pend_size_reg   <= '0;
            alt_reg         <= 1'b0;
            shift_reg       <= 1'b0;
            single_kind_reg <= KIND_DATA;
            out_valid_reg   <= 1'b0;
            out_kind_reg    <= KIND_DATA;
            out_last_reg    <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            rd_ptr_reg      <= rd_ptr_next;
            wr_ptr_reg      <= wr_ptr_next;
            count_reg       <= count_next;
            remain_reg      <= remain_next;
            pending_reg     <= pending_next;
            pend_size_reg   <= pend_size_next;
            alt_reg         <= alt_next;
            shift_reg       <= shift_next;
            single_kind_reg <= single_kind_next;
            out_valid_reg   <= out_valid_next;
            out_kind_reg    <= out_kind_next;
            out_last_reg    <= out_last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ring_we)
            ring[wr_ptr_reg] <= ch;
    end

    // Non-data results carry a zero byte.
    always_ff @(posedge clk)
    begin
        if (load_byte)
            data_byte_reg <= ring[rd_ptr_reg];
        else if (state_reg == ST_SINGLE && slot_free)
            data_byte_reg <= 8'h00;
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= BUFFER_DEPTH)
        else $error("stored count exceeds ring depth");

    a_deliver_covered: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DELIVER) |-> (remain_reg != '0 && remain_reg <= count_reg))
        else $error("delivery asks for more bytes than are stored");

    a_pending_short: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg |-> (count_reg < pend_size_reg && state_reg != ST_DELIVER))
        else $error("pending read left waiting with enough bytes stored");

    a_last_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
        (load_byte && remain_reg == CNT_W'(1)) |=> (out_last_reg && state_reg == ST_IDLE))
        else $error("final delivered byte not marked last");
`endif

endmodule

// File: tb/scancode_checker.sv
// Checker that predicts keyboard ring results from accepted requests and compares them.
`timescale 1ns / 100ps

module scancode_checker (
    input  logic clk,
    input  logic rst_n,
    ksrb_req_if  req,
    ksrb_rsp_if  rsp,
    output int   mismatches,
    output int   expected_left
);
    import ksrb_pkg::*;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data_byte;
        logic       last;
    } key_result_t;

    key_result_t due_results[$];
    key_result_t burst[$];

    logic [7:0]       glyph [0:255];
    logic [7:0]       ring_mem [0:BUFFER_DEPTH-1];
    logic [PTR_W-1:0] rd_ptr = '0;
    logic [PTR_W-1:0] wr_ptr = '0;
    logic [CNT_W-1:0] fill = '0;
    logic             read_waiting = 1'b0;
    logic [5:0]       wanted = '0;
    logic             alt_down = 1'b0;
    logic             shift_down = 1'b0;

    initial mismatches = 0;
    initial expected_left = 0;

    // Letter rows of the keyboard sit on consecutive set 1 codes.
    initial
    begin : build_glyphs
        string top_row;
        string home_row;
        string low_row;
        string digit_row;
        top_row   = "qwertyuiop";
        home_row  = "asdfghjkl";
        low_row   = "zxcvbnm";
        digit_row = "1234567890";
        for (int i = 0; i < 256; i++)
            glyph[i] = 8'h00;
        for (int i = 0; i < top_row.len(); i++)
            glyph[8'h10 + i] = top_row[i];
        for (int i = 0; i < home_row.len(); i++)
            glyph[8'h1e + i] = home_row[i];
        for (int i = 0; i < low_row.len(); i++)
            glyph[8'h2c + i] = low_row[i];
        for (int i = 0; i < digit_row.len(); i++)
            glyph[8'h02 + i] = digit_row[i];
        for (int i = 8'h3b; i <= 8'h44; i++)
            glyph[i] = "_";
        glyph[8'h57] = "_";
        glyph[8'h58] = "_";
        glyph[8'h34] = ".";
        glyph[8'h39] = " ";
        glyph[8'h1c] = 8'h0a;
        glyph[8'h0f] = 8'h09;
        glyph[8'h0e] = 8'h08;
    end

    task automatic hand_out(input int count);
        for (int i = 0; i < count && fill != '0; i++)
        begin
            burst.push_back('{kind: KIND_DATA, data_byte: ring_mem[rd_ptr], last: 1'b0});
            rd_ptr = (rd_ptr == PTR_W'(BUFFER_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
            fill   = fill - CNT_W'(1);
        end
    endtask

    task automatic step_keyboard(input logic c, input logic [7:0] sc, input logic [5:0] sz);
        logic [7:0]  ch;
        key_result_t rec;
        burst.delete();
        if (c == CMD_SCAN)
        begin
            // The console switch looks at the modifiers held before this code.
            if (alt_down && shift_down)
            begin
                if (sc == SC_RIGHT)
                    burst.push_back('{kind: KIND_SW_RIGHT, data_byte: 8'h00, last: 1'b0});
                else if (sc == SC_LEFT)
                    burst.push_back('{kind: KIND_SW_LEFT, data_byte: 8'h00, last: 1'b0});
            end
            if (sc == SC_ALT)
                alt_down = 1'b1;
            else if (sc == SC_SHIFT)
                shift_down = 1'b1;
            else if (sc == (SC_ALT | SC_RELEASE))
                alt_down = 1'b0;
            else if (sc == (SC_SHIFT | SC_RELEASE))
                shift_down = 1'b0;
            ch = glyph[sc];
            if (ch != 8'h00 && 32'(fill) < BUFFER_DEPTH)
            begin
                ring_mem[wr_ptr] = ch;
                wr_ptr = (wr_ptr == PTR_W'(BUFFER_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
                fill   = fill + CNT_W'(1);
                if (read_waiting && fill >= wanted)
                begin
                    read_waiting = 1'b0;
                    hand_out(int'(wanted));
                    wanted = '0;
                end
            end
        end
        else
        begin
            if (32'(sz) > BUFFER_DEPTH)
                burst.push_back('{kind: KIND_TOO_LARGE, data_byte: 8'h00, last: 1'b0});
            else if (read_waiting)
                burst.push_back('{kind: KIND_BUSY, data_byte: 8'h00, last: 1'b0});
            else if (fill >= sz)
                hand_out(int'(sz));
            else
            begin
                read_waiting = 1'b1;
                wanted       = sz;
            end
        end
        for (int i = 0; i < burst.size(); i++)
        begin
            rec      = burst[i];
            rec.last = (i == burst.size() - 1);
            due_results.push_back(rec);
        end
    endtask

    // Results are checked before the request of the same edge is predicted.
    always @(posedge clk)
    begin
        key_result_t want;
        if (rst_n)
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (due_results.size() == 0)
                begin
                    $display("%0t: result with none due: kind %0d byte %02h last %0d",
                             $time, rsp.kind, rsp.data_byte, rsp.last);
                    mismatches++;
                end
                else
                begin
                    want = due_results.pop_front();
                    if (rsp.kind !== want.kind)
                    begin
                        $display("%0t: kind expected %0d actual %0d",
                                 $time, want.kind, rsp.kind);
                        mismatches++;
                    end
                    if (rsp.data_byte !== want.data_byte)
                    begin
                        $display("%0t: data_byte expected %02h actual %02h",
                                 $time, want.data_byte, rsp.data_byte);
                        mismatches++;
                    end
                    if (rsp.last !== want.last)
                    begin
                        $display("%0t: last expected %0d actual %0d",
                                 $time, want.last, rsp.last);
                        mismatches++;
                    end
                end
            end
            if (req.valid && req.ready)
                step_keyboard(req.cmd, req.key_code, req.read_size);
        end
        expected_left <= due_results.size();
    end

endmodule

// File: tb/testbench.sv
// Top of the keyboard ring testbench: clock, reset, request and result pacing, verdict.
`timescale 1ns / 100ps

module testbench;
    import ksrb_pkg::*;

    localparam int HOLD_CYCLES = 400;
    localparam int QUIET_LIMIT = 4000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic calm = 1'b0;
    int   hold_requests = 0;
    int   sent_count = 0;
    int   mismatches;
    int   expected_left;

    ksrb_req_if req ();
    ksrb_rsp_if rsp ();

    keyboard_scancode_ring_buffer dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    scancode_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .req           (req),
        .rsp           (rsp),
        .mismatches    (mismatches),
        .expected_left (expected_left)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] pick_char_code();
        case ($urandom_range(0, 5))
            0: return 8'($urandom_range(8'h02, 8'h0b));
            1: return 8'($urandom_range(8'h10, 8'h19));
            2: return 8'($urandom_range(8'h1e, 8'h26));
            3: return 8'($urandom_range(8'h2c, 8'h32));
            4:
            begin
                case ($urandom_range(0, 4))
                    0: return 8'h0e;
                    1: return 8'h0f;
                    2: return 8'h1c;
                    3: return 8'h39;
                    default: return 8'h34;
                endcase
            end
            default: return ($urandom_range(0, 5) == 0) ? 8'($urandom_range(8'h57, 8'h58))
                                                         : 8'($urandom_range(8'h3b, 8'h44));
        endcase
    endfunction

    function automatic logic [7:0] pick_modifier();
        case ($urandom_range(0, 3))
            0: return SC_ALT;
            1: return SC_SHIFT;
            2: return SC_ALT | SC_RELEASE;
            default: return SC_SHIFT | SC_RELEASE;
        endcase
    endfunction

    // Called at a rising edge; returns at the edge where the transfer happened.
    task automatic send_item(input logic c, input logic [7:0] sc, input logic [5:0] sz);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid     <= 1'b1;
        req.cmd       <= c;
        req.key_code  <= sc;
        req.read_size <= sz;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        sent_count++;
    endtask

    task automatic send_scan(input logic [7:0] sc);
        send_item(CMD_SCAN, sc, 6'($urandom));
    endtask

    task automatic send_read(input logic [5:0] sz);
        send_item(CMD_READ, 8'($urandom), sz);
    endtask

    task automatic drain();
        req.valid <= 1'b0;
        @(posedge clk);
        while (expected_left != 0)
            @(posedge clk);
    endtask

    task automatic random_item();
        int         r;
        logic [7:0] arrow;
        r = $urandom_range(0, 99);
        arrow = ($urandom_range(0, 1) == 1) ? SC_RIGHT : SC_LEFT;
        if (r < 52)
            send_scan(pick_char_code());
        else if (r < 60)
            send_scan(pick_modifier());
        else if (r < 64)
            send_scan(arrow);
        else if (r < 68)
        begin
            // A full console switch chord: hold both modifiers, hit an arrow, let go.
            send_scan(SC_ALT);
            send_scan(SC_SHIFT);
            send_scan(arrow);
            send_scan(SC_SHIFT | SC_RELEASE);
            send_scan(SC_ALT | SC_RELEASE);
        end
        else if (r < 76)
            send_scan(8'($urandom));
        else if (r < 95)
        begin
            if ($urandom_range(0, 99) < 70)
                send_read(6'($urandom_range(0, 8)));
            else
                send_read(6'($urandom_range(0, BUFFER_DEPTH)));
        end
        else
            send_read(6'($urandom_range(BUFFER_DEPTH + 1, 63)));
    endtask

    initial
    begin : rsp_pacing
        int stall;
        int holds_done;
        int r;
        stall      = 0;
        holds_done = 0;
        rsp.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (holds_done != hold_requests)
            begin
                holds_done = hold_requests;
                stall      = HOLD_CYCLES;
            end
            else if (stall == 0 && !calm)
            begin
                r = $urandom_range(0, 99);
                if (r < 20)
                    stall = $urandom_range(1, 3);
                else if (r < 24)
                    stall = $urandom_range(8, 40);
            end
            if (stall > 0)
            begin
                rsp.ready <= 1'b0;
                stall--;
            end
            else
                rsp.ready <= 1'b1;
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("testbench: errors");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        req.valid     <= 1'b0;
        req.cmd       <= CMD_SCAN;
        req.key_code  <= 8'h00;
        req.read_size <= 6'd0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: size extremes, every character class, busy and wake-up reads, switches.
        send_read(6'd0);
        send_read(6'd63);
        send_scan(8'h1e);
        send_scan(8'h0b);
        send_scan(8'h0e);
        send_scan(8'h1c);
        send_scan(8'h0f);
        send_scan(8'h39);
        send_scan(8'h34);
        send_scan(8'h3b);
        send_scan(8'h58);
        send_scan(8'hff);
        send_read(6'd9);
        send_read(6'd2);
        send_read(6'd1);
        send_read(6'd40);
        send_scan(8'h2c);
        send_scan(8'h2d);
        send_scan(SC_ALT);
        send_scan(SC_SHIFT);
        send_scan(SC_RIGHT);
        send_scan(SC_LEFT);
        send_scan(SC_RIGHT | SC_RELEASE);
        send_scan(SC_ALT | SC_RELEASE);
        send_scan(SC_RIGHT);
        send_scan(SC_SHIFT | SC_RELEASE);
        drain();

        // Overfill the ring while results are blocked, then read it all back.
        calm <= 1'b1;
        hold_requests <= hold_requests + 1;
        for (int i = 0; i < 36; i++)
            send_scan(pick_char_code());
        send_read(6'(BUFFER_DEPTH));
        send_read(6'd3);
        send_read(6'd5);
        for (int i = 0; i < 3; i++)
            send_scan(pick_char_code());
        send_read(6'd2);
        drain();
        calm <= 1'b0;

        for (int phase = 0; phase < 3; phase++)
        begin
            calm <= (phase == 2);
            sent_count = 0;
            while (sent_count < 25)
                random_item();
            drain();
        end

        repeat (30) @(posedge clk);
        if (mismatches == 0 && expected_left == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

// File: files.f
design/ksrb_pkg.sv
design/ksrb_ifs.sv
design/keyboard_scancode_ring_buffer.sv
tb/scancode_checker.sv
tb/testbench.sv
